### rtl/tkfk_pkg.sv
// Shared types, constants and fitness compare helpers for the top-k keeper.
package tkfk_pkg;
	localparam int Capacity = 128;
	localparam int IdxW = $clog2(Capacity);
	localparam int CntW = $clog2(Capacity + 1);
	localparam logic [7:0] RecordSizeReset = 8'd100;
	localparam logic ActOffer = 1'b0;
	localparam logic ActRead = 1'b1;
	localparam logic [1:0] RegRecordSize = 2'd0;

	typedef struct packed {
		logic [63:0] value;
		logic [63:0] fitness;
	} entry_t;

	// Map double bits to an unsigned key whose order matches numeric order; -0 maps like +0.
	function automatic logic [63:0] fit_key(input logic [63:0] f);
		logic [63:0] m;
		m = (f[62:0] == 63'd0) ? 64'd0 : f;
		fit_key = m[63] ? ~m : {1'b1, m[62:0]};
	endfunction
endpackage

### rtl/top_k_fitness_keeper.sv
// Top-k fitness keeper: 128 compare cells work in parallel; the cells from the insertion point on
// shift once per accepted offer, and the result sits in an output register.
// Fitness is the raw double bits, NaN and infinity are dropped, ties keep the older pair first.
module top_k_fitness_keeper import tkfk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [63:0] cand_value,
	input  logic [63:0] cand_fitness,
	input  logic [6:0]  read_rank,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic        evicted,
	output logic [7:0]  held_count,
	output logic        rank_valid,
	output logic [63:0] rank_value,
	output logic [63:0] rank_fitness
);
	logic [7:0] record_size_q;
	logic [CntW-1:0] count_q;
	logic [Capacity-1:0] goes;
	entry_t ent [Capacity];
	entry_t cand;
	logic in_acc, finite, full, do_ins, do_ev;
	logic [CntW-1:0] limit;
	logic [63:0] ckey;

	assign pready = 1'b1;
	assign prdata = {24'd0, record_size_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_size_q <= RecordSizeReset;
		end else if (psel && penable && pwrite && paddr == RegRecordSize) begin
			record_size_q <= pwdata[7:0];
		end
	end

	assign in_stall = out_valid && out_stall;
	assign in_acc = in_valid && !in_stall;
	assign cand = '{value: cand_value, fitness: cand_fitness};
	assign ckey = fit_key(cand_fitness);
	assign finite = cand_fitness[62:52] != 11'h7ff;
	assign limit = ({1'b0, record_size_q} > 9'(Capacity)) ? CntW'(Capacity)
		: CntW'(record_size_q);
	assign full = count_q >= limit;
	// Past the last valid cell the offer always goes; evict needs a hit inside.
	assign do_ins = in_acc && action == ActOffer && finite
		&& (!full || (count_q != '0 && goes[count_q[IdxW-1:0] - IdxW'(1)]));
	assign do_ev = do_ins && full;

	for (genvar i = 0; i < Capacity; i++) begin : g_cell
		logic upg;
		entry_t upe;
		if (i == 0) begin : g_head
			assign upg = 1'b0;
			assign upe = cand;
		end else begin : g_body
			assign upg = goes[i-1];
			assign upe = ent[i-1];
		end
		tkfk_cell u_cell (
			.clk(clk), .shift_en(do_ins),
			.cand_key_ge(fit_key(ent[i].fitness) >= ckey),
			.up_goes(upg), .up_entry(upe), .cand(cand),
			.own_valid(CntW'(i) < count_q),
			.goes(goes[i]), .entry(ent[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (do_ins && !full) count_q <= count_q + CntW'(1);
			if (in_acc) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	logic rv;
	assign rv = action == ActRead && CntW'(read_rank) < count_q;
	always_ff @(posedge clk) begin
		if (in_acc) begin
			accepted <= do_ins;
			evicted <= do_ev;
			held_count <= 8'((do_ins && !full) ? count_q + CntW'(1) : count_q);
			rank_valid <= rv;
			rank_value <= rv ? ent[read_rank].value : 64'd0;
			rank_fitness <= rv ? ent[read_rank].fitness : 64'd0;
		end
	end

	a_ev_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted |-> accepted) else $error("evict without accept");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Capacity)) else $error("count overflow");
	a_rd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rank_valid |-> !accepted) else $error("read accepted");
endmodule

### rtl/tkfk_cell.sv
// One rank slot of the sorted chain: uses the offer compare and loads from its upper neighbor or the offer.
module tkfk_cell import tkfk_pkg::*; (
	input  logic   clk,
	input  logic   shift_en,
	input  logic   cand_key_ge,
	input  logic   up_goes,
	input  entry_t up_entry,
	input  entry_t cand,
	input  logic   own_valid,
	output logic   goes,
	output entry_t entry
);
	entry_t entry_q;
	// The offer lands at or above this slot when this slot is empty or its fitness is below it.
	assign goes = !own_valid || !cand_key_ge;
	assign entry = entry_q;
	always_ff @(posedge clk) begin
		if (shift_en && goes) begin
			entry_q <= up_goes ? up_entry : cand;
		end
	end
endmodule

### test/tb_top.sv
// Self-checking testbench for the top-k fitness keeper: directed specials and random traffic against an internal model.
module tb_top;
	import tkfk_pkg::*;

	typedef struct {
		bit        accepted;
		bit        evicted;
		bit [7:0]  held_count;
		bit        rank_valid;
		bit [63:0] rank_value;
		bit [63:0] rank_fitness;
	} keeper_result_t;

	class fitness_board;
		bit [63:0] kept_val[Capacity];
		bit [63:0] kept_fit[Capacity];
		int unsigned held;
		int unsigned record_limit;
		int unsigned errors;
		keeper_result_t expected_q[$];

		function new();
			held = 0;
			record_limit = RecordSizeReset;
			errors = 0;
		endfunction

		function void note_item(bit act, bit [63:0] val, bit [63:0] fit, bit [6:0] rank);
			keeper_result_t r;
			int unsigned lim;
			int unsigned pos;
			int unsigned last;
			real f;
			r = '{default: '0};
			if (act == ActOffer) begin
				lim = (record_limit > Capacity) ? Capacity : record_limit;
				if (fit[62:52] != 11'h7ff) begin
					f = $bitstoreal(fit);
					pos = 0;
					while (pos < held && $bitstoreal(kept_fit[pos]) >= f)
						pos++;
					// room left: grow; full: drop the minimum only if beaten
					last = held;
					if (held < lim) begin
						held++;
						r.accepted = 1;
					end else if (held > 0 && pos < held) begin
						last = held - 1;
						r.accepted = 1;
						r.evicted = 1;
					end
					if (r.accepted) begin
						for (int unsigned i = last; i > pos; i--) begin
							kept_val[i] = kept_val[i - 1];
							kept_fit[i] = kept_fit[i - 1];
						end
						kept_val[pos] = val;
						kept_fit[pos] = fit;
					end
				end
			end else if (rank < held) begin
				r.rank_valid = 1;
				r.rank_value = kept_val[rank];
				r.rank_fitness = kept_fit[rank];
			end
			r.held_count = held[7:0];
			expected_q.insert(expected_q.size(), r);
		endfunction

		function void check_result(keeper_result_t got);
			keeper_result_t e;
			if (expected_q.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.accepted !== e.accepted) begin
				$error("accepted: expected %0d, got %0d", e.accepted, got.accepted);
				errors++;
			end
			if (got.evicted !== e.evicted) begin
				$error("evicted: expected %0d, got %0d", e.evicted, got.evicted);
				errors++;
			end
			if (got.held_count !== e.held_count) begin
				$error("held_count: expected %0d, got %0d", e.held_count, got.held_count);
				errors++;
			end
			if (got.rank_valid !== e.rank_valid) begin
				$error("rank_valid: expected %0d, got %0d", e.rank_valid, got.rank_valid);
				errors++;
			end
			if (got.rank_value !== e.rank_value) begin
				$error("rank_value: expected %h, got %h", e.rank_value, got.rank_value);
				errors++;
			end
			if (got.rank_fitness !== e.rank_fitness) begin
				$error("rank_fitness: expected %h, got %h", e.rank_fitness, got.rank_fitness);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid, in_stall;
	logic        action;
	logic [63:0] cand_value, cand_fitness;
	logic [6:0]  read_rank;
	logic        out_valid, out_stall;
	logic        accepted, evicted, rank_valid;
	logic [7:0]  held_count;
	logic [63:0] rank_value, rank_fitness;

	fitness_board board = new();
	bit quiet;
	bit hold_req;
	bit [63:0] tie_pool[8];

	top_k_fitness_keeper i_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("[top_k_fitness_keeper] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		keeper_result_t got;
		if (arst_n && in_valid && !in_stall)
			board.note_item(action, cand_value, cand_fitness, read_rank);
		if (arst_n && out_valid && !out_stall) begin
			got.accepted = accepted;
			got.evicted = evicted;
			got.held_count = held_count;
			got.rank_valid = rank_valid;
			got.rank_value = rank_value;
			got.rank_fitness = rank_fitness;
			board.check_result(got);
		end
	end

	// receiver: random stall before each result, one long hold-off on request
	initial begin
		int unsigned n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_req = 0;
			end
			n = quiet ? 0 : $urandom_range(0, 9);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		board.record_limit = data[7:0];
	endtask

	task automatic set_record_size(input int unsigned size);
		// let the last accepted item reach the board before draining
		repeat (2) @(posedge clk);
		wait (board.expected_q.size() == 0);
		repeat (4) @(posedge clk);
		apb_write(RegRecordSize, size);
	endtask

	task automatic send_item(input bit act, input bit [63:0] val, input bit [63:0] fit,
			input bit [6:0] rank);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		cand_value <= val;
		cand_fitness <= fit;
		read_rank <= rank;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic offer(input bit [63:0] fit);
		send_item(ActOffer, {$urandom, $urandom}, fit, 7'($urandom));
	endtask

	task automatic read_at(input bit [6:0] rank);
		send_item(ActRead, {$urandom, $urandom}, {$urandom, $urandom}, rank);
	endtask

	function automatic bit [63:0] pick_fitness();
		int unsigned k;
		bit [63:0] f;
		k = $urandom_range(0, 99);
		f = {$urandom, $urandom};
		if (k < 35)
			return tie_pool[$urandom_range(0, 7)];
		if (k < 40) begin
			// non-finite: NaN or infinity of either sign
			f[62:52] = 11'h7ff;
			if ($urandom_range(0, 1))
				f[51:0] = '0;
			return f;
		end
		if (k < 85)
			f[62:52] = 11'(11'h3f0 + $urandom_range(0, 31));
		else if (f[62:52] == 11'h7ff)
			f[62:52] = 11'h7fe;
		return f;
	endfunction

	task automatic random_phase(input int unsigned n_items);
		for (int unsigned i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 99) < 30)
				read_at(7'($urandom_range(0, 1) ? $urandom : $urandom_range(0, board.held)));
			else
				offer(pick_fitness());
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		int unsigned sizes[10] = '{1, 128, 0, 2, 200, 5, 255, 17, 128, 3};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		action = ActOffer;
		cand_value = '0;
		cand_fitness = '0;
		read_rank = '0;
		quiet = 0;
		hold_req = 0;
		for (int i = 0; i < 8; i++)
			tie_pool[i] = $realtobits(real'(i) - 3.0);
		tie_pool[7] = 64'h8000_0000_0000_0000;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: specials at the reset size
		read_at(0);
		offer($realtobits(1.0));
		offer(64'h0000_0000_0000_0000);
		offer(64'h8000_0000_0000_0000);
		offer(64'h7ff8_0000_0000_0001);
		offer(64'h7ff0_0000_0000_0000);
		offer(64'hfff0_0000_0000_0000);
		offer(64'hffff_ffff_ffff_ffff);
		offer(64'h7fef_ffff_ffff_ffff);
		offer(64'hffef_ffff_ffff_ffff);
		offer(64'h0000_0000_0000_0001);
		send_item(ActOffer, '1, $realtobits(1.0), '1);
		send_item(ActOffer, '0, $realtobits(1.0), '0);
		read_at(0);
		read_at(2);
		read_at(7);
		read_at(127);
		in_valid <= 1'b0;
		// lower the limit below the count
		set_record_size(3);
		offer(64'hffef_ffff_ffff_ffff);
		offer($realtobits(1.0));
		offer(64'h8000_0000_0000_0000);
		for (int r = 0; r < 4; r++)
			read_at(7'(r));
		in_valid <= 1'b0;

		for (int p = 0; p < 10; p++) begin
			set_record_size(sizes[p]);
			quiet = (p == 4);
			if (p == 3)
				hold_req = 1;
			random_phase(p == 1 ? 240 : 65);
		end
		quiet = 0;

		repeat (2) @(posedge clk);
		wait (board.expected_q.size() == 0);
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.expected_q.size() == 0)
			$display("[top_k_fitness_keeper] OK");
		else
			$display("[top_k_fitness_keeper] ERROR");
		$finish;
	end
endmodule
